// ===== rtl/ecrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ecrc_pkg
// Shared codes, byte constants, queue entry type and the crc fold function
// for the escaped frame crc encoder.
// ----------------------------------------------------------------------------
package ecrc_pkg;

  // input commands
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // operation kinds carried from front to back
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [7:0] DELIM_BYTE = 8'hC0;
  localparam logic [7:0] ESC_BYTE   = 8'hDB;
  localparam logic [7:0] ESC_DELIM  = 8'hDC;
  localparam logic [7:0] ESC_ESC    = 8'hDD;

  localparam logic [15:0] CRC_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

  // index of the last byte each operation sends
  localparam logic [1:0] START_LAST_IDX  = 2'd3;
  localparam logic [1:0] FINISH_LAST_IDX = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] last_idx;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } op_t;

  // reflected ccitt crc, one byte
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/ecrc_front.sv =====
// ----------------------------------------------------------------------------
// ecrc_front
// Accepts input requests, tracks whether a frame is open and turns a start,
// or a data or finish inside a frame, into a queued op with escaping resolved.
// ----------------------------------------------------------------------------
module ecrc_front
  import ecrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] command,
  input  logic [7:0] payload_byte,
  input  logic [7:0] dest_addr,
  input  logic [7:0] src_addr,
  input  logic [7:0] frame_kind,
  output logic       wr_en,
  output op_t        wr_op
);

  logic in_frame;
  logic in_frame_next;

  always_comb begin
    in_frame_next  = in_frame;
    wr_en          = 1'b0;
    wr_op.kind     = OP_DATA;
    wr_op.last_idx = 2'd0;
    wr_op.byte0    = payload_byte;
    wr_op.byte1    = 8'h00;
    wr_op.byte2    = 8'h00;
    case (command)
      CMD_START: begin
        wr_en          = accept;
        wr_op.kind     = OP_START;
        wr_op.last_idx = START_LAST_IDX;
        wr_op.byte0    = dest_addr;
        wr_op.byte1    = src_addr;
        wr_op.byte2    = frame_kind;
        if (accept) begin
          in_frame_next = 1'b1;
        end
      end
      CMD_DATA: begin
        wr_en = accept && in_frame;
        if (payload_byte == DELIM_BYTE) begin
          wr_op.last_idx = 2'd1;
          wr_op.byte0    = ESC_BYTE;
          wr_op.byte1    = ESC_DELIM;
        end else if (payload_byte == ESC_BYTE) begin
          wr_op.last_idx = 2'd1;
          wr_op.byte0    = ESC_BYTE;
          wr_op.byte1    = ESC_ESC;
        end
      end
      CMD_FINISH: begin
        wr_en          = accept && in_frame;
        wr_op.kind     = OP_FINISH;
        wr_op.last_idx = FINISH_LAST_IDX;
        if (accept) begin
          in_frame_next = 1'b0;
        end
      end
      default: begin
        // unknown command is dropped
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
    end else begin
      in_frame <= in_frame_next;
    end
  end

endmodule

// ===== rtl/ecrc_queue.sv =====
// ----------------------------------------------------------------------------
// ecrc_queue
// Short operation queue between the front and back parts.
// ----------------------------------------------------------------------------
module ecrc_queue
  import ecrc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  op_t  wr_op,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output op_t  rd_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_op    = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ecrc_back.sv =====
// ----------------------------------------------------------------------------
// ecrc_back
// Sends queued operations' bytes, one per cycle unless an unpopped byte stalls
// it, keeps the running crc and holds the oldest result in an output register.
// ----------------------------------------------------------------------------
module ecrc_back
  import ecrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       op_valid,
  input  op_t        op,
  output logic       op_done,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       frame_end
);

  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [1:0]  idx;
  logic        out_valid;

  logic        step;
  logic        is_last;
  logic [7:0]  cur_byte;
  logic        fold;
  logic        cur_end;

  assign step    = op_valid && (!out_valid || pop);
  assign is_last = (idx == op.last_idx);
  assign op_done = step && is_last;
  assign empty   = !out_valid;

  always_comb begin
    cur_byte = op.byte0;
    fold     = 1'b1;
    cur_end  = 1'b0;
    crc_next = crc;
    case (op.kind)
      OP_START: begin
        case (idx)
          2'd0: begin
            cur_byte = DELIM_BYTE;
            fold     = 1'b0;
          end
          2'd1:    cur_byte = op.byte0;
          2'd2:    cur_byte = op.byte1;
          default: cur_byte = op.byte2;
        endcase
      end
      OP_DATA: begin
        cur_byte = idx[0] ? op.byte1 : op.byte0;
      end
      default: begin
        fold = 1'b0;
        case (idx)
          2'd0: cur_byte = crc[7:0];
          2'd1: cur_byte = crc[15:8];
          default: begin
            cur_byte = DELIM_BYTE;
            cur_end  = 1'b1;
          end
        endcase
      end
    endcase
    // start reseeds on its delimiter, finish reseeds after its last byte
    if ((op.kind == OP_START) && (idx == 2'd0)) begin
      crc_next = CRC_SEED;
    end else if ((op.kind == OP_FINISH) && is_last) begin
      crc_next = CRC_SEED;
    end else if (fold) begin
      crc_next = crc_fold(crc, cur_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc       <= CRC_SEED;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        crc       <= crc_next;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte  <= cur_byte;
      last      <= is_last;
      frame_end <= cur_end;
    end
  end

endmodule

// ===== rtl/escaped_frame_crc_encoder.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_crc_encoder
// Framed serial transmitter with byte escaping and crc-16 trailer.
// ----------------------------------------------------------------------------
// A start request sends 0xC0 and three raw header bytes, a payload request
// sends its byte or an escape pair, a finish request sends the crc low byte,
// high byte and 0xC0; dropped requests send nothing. The rate is set by the
// back end, which sends one byte per cycle and folds it into the crc in the
// same cycle. The front end accepts a request every cycle while the operation
// queue (QUEUE_DEPTH entries) has room, and the output register is refilled in
// the same cycle its byte is popped, so bytes go out back to back while pop
// stays high; while a byte waits unpopped the back end holds and the queue
// absorbs new requests.
module escaped_frame_crc_encoder
  import ecrc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command,
  input  logic [7:0] payload_byte,
  input  logic [7:0] dest_addr,
  input  logic [7:0] src_addr,
  input  logic [7:0] frame_kind,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       frame_end
);

  logic accept;
  logic wr_en;
  op_t  wr_op;
  logic rd_valid;
  op_t  rd_op;
  logic op_done;

  assign accept = push && !full;

  ecrc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (command),
    .payload_byte (payload_byte),
    .dest_addr    (dest_addr),
    .src_addr     (src_addr),
    .frame_kind   (frame_kind),
    .wr_en        (wr_en),
    .wr_op        (wr_op)
  );

  ecrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_op    (wr_op),
    .full     (full),
    .rd_en    (op_done),
    .rd_valid (rd_valid),
    .rd_op    (rd_op)
  );

  ecrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (rd_valid),
    .op        (rd_op),
    .op_done   (op_done),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .last      (last),
    .frame_end (frame_end)
  );

endmodule

// ===== tb/sv/frame_byte_checker.sv =====
// ----------------------------------------------------------------------------
// frame_byte_checker
// Watches both sides of the escaped frame crc encoder. Every accepted
// request is turned into the line bytes it must produce: header, escaped
// payload and crc trailer. Each popped byte is compared against the oldest
// predicted one.
// ----------------------------------------------------------------------------
module frame_byte_checker
  import ecrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] command,
  input  logic [7:0] payload_byte,
  input  logic [7:0] dest_addr,
  input  logic [7:0] src_addr,
  input  logic [7:0] frame_kind,
  input  logic       pop,
  input  logic       empty,
  input  logic [7:0] out_byte,
  input  logic       last,
  input  logic       frame_end,
  output int         errors,
  output int         pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       frame_end;
  } line_byte_t;

  line_byte_t  expected_bytes[$];
  logic [15:0] crc_acc;
  logic        frame_open;

  // bitwise reflected crc, lsb first
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ b[i]) ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

  task automatic predict_frame_bytes(input logic [1:0] cmd, input logic [7:0] pay,
                                     input logic [7:0] dst, input logic [7:0] src,
                                     input logic [7:0] knd);
    logic [7:0] seq [4];
    int         n;
    line_byte_t e;
    n = 0;
    case (cmd)
      CMD_START: begin
        // a start reseeds even when a frame is already open
        frame_open = 1'b1;
        seq[0] = DELIM_BYTE;
        seq[1] = dst;
        seq[2] = src;
        seq[3] = knd;
        n = 4;
        crc_acc = crc_next(crc_next(crc_next(CRC_SEED, dst), src), knd);
      end
      CMD_DATA: begin
        if (frame_open) begin
          if (pay == DELIM_BYTE) begin
            seq[0] = ESC_BYTE;
            seq[1] = ESC_DELIM;
            n = 2;
          end else if (pay == ESC_BYTE) begin
            seq[0] = ESC_BYTE;
            seq[1] = ESC_ESC;
            n = 2;
          end else begin
            seq[0] = pay;
            n = 1;
          end
          // crc runs over the bytes as they go out on the line
          for (int i = 0; i < n; i++) begin
            crc_acc = crc_next(crc_acc, seq[i]);
          end
        end
      end
      CMD_FINISH: begin
        if (frame_open) begin
          seq[0] = crc_acc[7:0];
          seq[1] = crc_acc[15:8];
          seq[2] = DELIM_BYTE;
          n = 3;
          crc_acc = CRC_SEED;
          frame_open = 1'b0;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < n; i++) begin
      e.data      = seq[i];
      e.last      = (i == n - 1);
      e.frame_end = (cmd == CMD_FINISH) && (i == 2);
      expected_bytes.push_back(e);
    end
  endtask

  always @(posedge clk) begin : watch
    line_byte_t want;
    if (rst) begin
      expected_bytes.delete();
      crc_acc    = CRC_SEED;
      frame_open = 1'b0;
      errors     = 0;
    end else begin
      if (push && !full) begin
        predict_frame_bytes(command, payload_byte, dest_addr, src_addr, frame_kind);
      end
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: byte with nothing expected, got out_byte %h last %b frame_end %b",
                   $time, out_byte, last, frame_end);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            errors++;
            $display("%0t: out_byte expected %h got %h", $time, want.data, out_byte);
          end
          if (last !== want.last) begin
            errors++;
            $display("%0t: last expected %b got %b", $time, want.last, last);
          end
          if (frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %b got %b", $time, want.frame_end, frame_end);
          end
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// ===== tb/sv/escaped_frame_crc_encoder_test.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_crc_encoder_test
// Drives command requests into the encoder and pops the line bytes with
// random gaps and stalls. A directed run covers header, escaping and stray
// command cases, then random frames with some noise run under several idle
// patterns. Checking is done by frame_byte_checker.
// ----------------------------------------------------------------------------
module escaped_frame_crc_encoder_test;
  import ecrc_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         DRAIN_CYCLES = 16;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       push         = 1'b0;
  logic [1:0] command      = CMD_START;
  logic [7:0] payload_byte = 8'h00;
  logic [7:0] dest_addr    = 8'h00;
  logic [7:0] src_addr     = 8'h00;
  logic [7:0] frame_kind   = 8'h00;
  logic       pop          = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       last;
  logic       frame_end;

  int fail_count;
  int bytes_pending;
  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int rx_hold_cycles = 0;
  int frame_items    = 0;

  escaped_frame_crc_encoder uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .payload_byte (payload_byte),
    .dest_addr    (dest_addr),
    .src_addr     (src_addr),
    .frame_kind   (frame_kind),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .last         (last),
    .frame_end    (frame_end)
  );

  frame_byte_checker chk (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .payload_byte (payload_byte),
    .dest_addr    (dest_addr),
    .src_addr     (src_addr),
    .frame_kind   (frame_kind),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .last         (last),
    .frame_end    (frame_end),
    .errors       (fail_count),
    .pending      (bytes_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // line side: random stalls, or a counted hold-off when one is asked for
  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else if (rx_hold_cycles > 0) begin
      pop = 1'b0;
      rx_hold_cycles--;
    end else begin
      pop = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    #(LIMIT_CYCLES * 4);
    $display("FAIL");
    $finish;
  end

  // biased toward the two bytes that need escaping
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(9))
      0: v = DELIM_BYTE;
      1: v = ESC_BYTE;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  // one request, held until the block takes it
  task automatic offer(input logic [1:0] cmd, input logic [7:0] pay, input logic [7:0] dst,
                       input logic [7:0] src, input logic [7:0] knd);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push         = 1'b1;
    command      = cmd;
    payload_byte = pay;
    dest_addr    = dst;
    src_addr     = src;
    frame_kind   = knd;
    do @(posedge clk); while (full);
  endtask

  task automatic offer_random(input logic [1:0] cmd);
    offer(cmd, pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endtask

  task automatic send_random_frame(input int max_payload);
    int n;
    n = $urandom_range(max_payload);
    offer_random(CMD_START);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        offer_random(CMD_UNUSED);
      end
      offer_random(CMD_DATA);
    end
    offer_random(CMD_FINISH);
    frame_items += n + 2;
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: offer_random(CMD_UNUSED);
      1: offer_random(CMD_DATA);
      2: offer_random(CMD_FINISH);
      default: begin
        // frame left open, the next start abandons it
        offer_random(CMD_START);
        repeat ($urandom_range(3)) offer_random(CMD_DATA);
      end
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    wait (bytes_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // stray requests before any frame
    offer(CMD_DATA, 8'h55, 8'h00, 8'h00, 8'h00);
    offer(CMD_FINISH, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(CMD_DATA, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(CMD_DATA, 8'hFF, 8'h00, 8'h00, 8'h00);
    offer(CMD_DATA, DELIM_BYTE, 8'h00, 8'h00, 8'h00);
    offer(CMD_DATA, ESC_BYTE, 8'h00, 8'h00, 8'h00);
    offer(CMD_DATA, ESC_DELIM, 8'h00, 8'h00, 8'h00);
    offer(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(CMD_FINISH, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(CMD_START, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    offer(CMD_DATA, 8'h7F, 8'h00, 8'h00, 8'h00);
    // restart inside an open frame, header bytes go out raw
    offer(CMD_START, 8'h00, DELIM_BYTE, ESC_BYTE, 8'h02);
    offer(CMD_DATA, ESC_ESC, 8'h00, 8'h00, 8'h00);
    offer(CMD_FINISH, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(CMD_START, 8'h00, ESC_BYTE, DELIM_BYTE, 8'h03);
    offer(CMD_FINISH, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(CMD_DATA, 8'hA5, 8'h00, 8'h00, 8'h00);
    offer(CMD_FINISH, 8'h00, 8'h00, 8'h00, 8'h00);

    // line side held off while a long frame keeps coming
    rx_hold_cycles = 150;
    offer_random(CMD_START);
    repeat (20) offer_random(CMD_DATA);
    offer_random(CMD_FINISH);
    frame_items += 22;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 63;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 63;
        end
        default: begin
          tx_idle_pct  = 19;
          rx_stall_pct = 19;
        end
      endcase
      target = frame_items + 12;
      while (frame_items < target) begin
        if ($urandom_range(99) < 80) begin
          send_random_frame(6);
        end else begin
          send_noise();
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
